// File: design/sts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared sizes, operation codes and the structs that pass between modules.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int OP_W        = 2;
   localparam int POS_W       = 6;
   localparam int RSP_TDATA_W = 8;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
   localparam logic [OP_W-1:0] OP_LINEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_BINARY = 2'd3;

   typedef struct packed {
      logic eq;
      logic gt;
   } cmp_type;

   typedef struct packed {
      logic             overflow;
      logic [POS_W-1:0] position;
      logic             found;
   } result_type;

   // The reported position is the table index taken modulo 2**POS_W.
   function automatic logic [POS_W-1:0] pos_of(input logic [IDX_W-1:0] idx);
      logic [POS_W+IDX_W-1:0] ext;
      ext = {{POS_W{1'b0}}, idx};
      return ext[POS_W-1:0];
   endfunction

endpackage

// File: design/sts_cmp.sv
// ----------------------------------------------------------------------------
// Shared compare unit
// Signed equality and greater-than test used by the sort and both searches.
// ----------------------------------------------------------------------------
module sts_cmp (
   input  logic signed [sts_pkg::DATA_W-1:0] a,
   input  logic signed [sts_pkg::DATA_W-1:0] b,
   output sts_pkg::cmp_type                  result
);

   assign result.eq = (a == b);
   assign result.gt = (a > b);

endmodule

// File: design/sts_engine.sv
// ----------------------------------------------------------------------------
// Table engine
// Table memory, insertion sort and linear/binary search sequencer built
// around one shared compare unit.
// ----------------------------------------------------------------------------
module sts_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [sts_pkg::OP_W-1:0]          in_op,
   input  logic signed [sts_pkg::DATA_W-1:0] in_value,
   output logic                              res_valid,
   input  logic                              res_take,
   output sts_pkg::result_type               res
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
   localparam logic [ST_W-1:0] S_SORT_I   = 4'd1;
   localparam logic [ST_W-1:0] S_SORT_V   = 4'd2;
   localparam logic [ST_W-1:0] S_SORT_CMP = 4'd3;
   localparam logic [ST_W-1:0] S_SORT_PUT = 4'd4;
   localparam logic [ST_W-1:0] S_START    = 4'd5;
   localparam logic [ST_W-1:0] S_LIN_CMP  = 4'd6;
   localparam logic [ST_W-1:0] S_BIN_MID  = 4'd7;
   localparam logic [ST_W-1:0] S_BIN_CMP  = 4'd8;
   localparam logic [ST_W-1:0] S_DONE     = 4'd9;

   logic [ST_W-1:0]                   state_ff, state_in;
   logic [sts_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                              sorted_ff, sorted_in;
   logic                              ovf_ff, ovf_in;
   logic signed [sts_pkg::DATA_W-1:0] key_ff, key_in;
   logic [sts_pkg::OP_W-1:0]          op_ff, op_in;
   logic signed [sts_pkg::DATA_W-1:0] v_ff, v_in;
   logic [sts_pkg::IDX_W-1:0]         i_ff, i_in;
   logic [sts_pkg::IDX_W-1:0]         j_ff, j_in;
   logic [sts_pkg::CNT_W-1:0]         lo_ff, lo_in;
   logic [sts_pkg::CNT_W-1:0]         hi_ff, hi_in;
   logic [sts_pkg::CNT_W-1:0]         mid_ff, mid_in;
   logic                              found_ff, found_in;
   logic [sts_pkg::POS_W-1:0]         pos_ff, pos_in;

   logic [sts_pkg::DATA_W-1:0]        mem_ff [sts_pkg::TABLE_DEPTH];
   logic signed [sts_pkg::DATA_W-1:0] rd_data_ff;
   logic [sts_pkg::IDX_W-1:0]         rd_addr;
   logic                              wr_en;
   logic [sts_pkg::IDX_W-1:0]         wr_addr;
   logic [sts_pkg::DATA_W-1:0]        wr_data;

   logic signed [sts_pkg::DATA_W-1:0] cmp_b;
   sts_pkg::cmp_type                  cmp;
   logic [sts_pkg::CNT_W-1:0]         i_next;
   logic [sts_pkg::CNT_W:0]           mid_sum;

   assign cmp_b = (state_ff == S_SORT_CMP) ? v_ff : key_ff;

   sts_cmp u_cmp (
      .a      (rd_data_ff),
      .b      (cmp_b),
      .result (cmp)
   );

   assign i_next   = {{(sts_pkg::CNT_W-sts_pkg::IDX_W){1'b0}}, i_ff} + sts_pkg::CNT_W'(1);
   // Midpoint of the inclusive range low .. end-1, never negative here.
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - (sts_pkg::CNT_W+1)'(1);

   assign in_ready     = (state_ff == S_IDLE);
   assign res_valid    = (state_ff == S_DONE);
   assign res.found    = found_ff;
   assign res.position = pos_ff;
   assign res.overflow = ovf_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      sorted_in = sorted_ff;
      ovf_in    = ovf_ff;
      key_in    = key_ff;
      op_in     = op_ff;
      v_in      = v_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               case (in_op)
                  sts_pkg::OP_CLEAR: begin
                     count_in  = '0;
                     sorted_in = 1'b1;
                  end
                  sts_pkg::OP_LOAD: begin
                     if (count_ff < sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH)) begin
                        wr_en     = 1'b1;
                        wr_addr   = count_ff[sts_pkg::IDX_W-1:0];
                        wr_data   = in_value;
                        count_in  = count_ff + sts_pkg::CNT_W'(1);
                        sorted_in = 1'b0;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  default: begin
                     key_in = in_value;
                     op_in  = in_op;
                     if (!sorted_ff && (count_ff > sts_pkg::CNT_W'(1))) begin
                        i_in     = sts_pkg::IDX_W'(1);
                        state_in = S_SORT_I;
                     end else begin
                        sorted_in = 1'b1;
                        state_in  = S_START;
                     end
                  end
               endcase
            end
         end
         S_SORT_I: begin
            rd_addr  = i_ff;
            state_in = S_SORT_V;
         end
         S_SORT_V: begin
            v_in     = rd_data_ff;
            j_in     = i_ff;
            rd_addr  = i_ff - sts_pkg::IDX_W'(1);
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if (cmp.gt) begin
               // Shift the larger entry up one place and keep walking down.
               wr_data = rd_data_ff;
               j_in    = j_ff - sts_pkg::IDX_W'(1);
               if (j_ff == sts_pkg::IDX_W'(1)) begin
                  state_in = S_SORT_PUT;
               end else begin
                  rd_addr = j_ff - sts_pkg::IDX_W'(2);
               end
            end else begin
               wr_data = v_ff;
               i_in    = i_ff + sts_pkg::IDX_W'(1);
               if (i_next == count_ff) begin
                  sorted_in = 1'b1;
                  state_in  = S_START;
               end else begin
                  state_in = S_SORT_I;
               end
            end
         end
         S_SORT_PUT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = v_ff;
            i_in    = i_ff + sts_pkg::IDX_W'(1);
            if (i_next == count_ff) begin
               sorted_in = 1'b1;
               state_in  = S_START;
            end else begin
               state_in = S_SORT_I;
            end
         end
         S_START: begin
            if (op_ff == sts_pkg::OP_LINEAR) begin
               if (count_ff == '0) begin
                  found_in = 1'b0;
                  pos_in   = '0;
                  state_in = S_DONE;
               end else begin
                  rd_addr  = '0;
                  i_in     = '0;
                  state_in = S_LIN_CMP;
               end
            end else begin
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_BIN_MID;
            end
         end
         S_LIN_CMP: begin
            if (cmp.eq) begin
               found_in = 1'b1;
               pos_in   = sts_pkg::pos_of(i_ff);
               state_in = S_DONE;
            end else if (i_next == count_ff) begin
               found_in = 1'b0;
               pos_in   = '0;
               state_in = S_DONE;
            end else begin
               i_in    = i_ff + sts_pkg::IDX_W'(1);
               rd_addr = i_ff + sts_pkg::IDX_W'(1);
            end
         end
         S_BIN_MID: begin
            if (lo_ff >= hi_ff) begin
               found_in = 1'b0;
               pos_in   = '0;
               state_in = S_DONE;
            end else begin
               mid_in   = mid_sum[sts_pkg::CNT_W:1];
               rd_addr  = mid_sum[sts_pkg::IDX_W:1];
               state_in = S_BIN_CMP;
            end
         end
         S_BIN_CMP: begin
            if (cmp.eq) begin
               found_in = 1'b1;
               pos_in   = sts_pkg::pos_of(mid_ff[sts_pkg::IDX_W-1:0]);
               state_in = S_DONE;
            end else if (cmp.gt) begin
               hi_in    = mid_ff;
               state_in = S_BIN_MID;
            end else begin
               lo_in    = mid_ff + sts_pkg::CNT_W'(1);
               state_in = S_BIN_MID;
            end
         end
         S_DONE: begin
            if (res_take) begin
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         sorted_ff <= 1'b1;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sorted_ff <= sorted_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      op_ff    <= op_in;
      v_ff     <= v_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_load_grows: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && (in_op == sts_pkg::OP_LOAD)
       && (count_ff < sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH)))
      |=> (count_ff == $past(count_ff) + sts_pkg::CNT_W'(1)) && !sorted_ff)
      else $error("accepted load did not append an entry");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && (in_op == sts_pkg::OP_CLEAR))
      |=> (count_ff == '0) && sorted_ff)
      else $error("clear did not empty the table");

   a_result_sorted: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> sorted_ff)
      else $error("search result given from an unsorted table");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res.found) |-> (res.position == '0))
      else $error("miss reported a non-zero position");

endmodule

// File: design/sorted_table_search.sv
// ----------------------------------------------------------------------------
// Sorted table search
// Table of signed 32-bit values with clear, load, linear and binary search.
// ----------------------------------------------------------------------------
// Clear and load complete without leaving the idle state. A search over n entries
// first sorts the table if loads have happened, by insertion on the table memory
// with its one read and one write port. Linear search then walks up to n entries;
// binary search reads and compares a midpoint per halving step.
// Reset empties the table and clears the overflow flag; the table memory
// itself is not cleared and there is no clearing pass.
module sorted_table_search (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sts_pkg::DATA_W-1:0]         req_tdata,  // [31:0] value
   input  logic [sts_pkg::OP_W-1:0]           req_tuser,  // [1:0] opcode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sts_pkg::RSP_TDATA_W-1:0]    rsp_tdata   // [0] found, [6:1] position,
                                                          // [7] overflow
);

   logic                               res_valid;
   logic                               res_take;
   sts_pkg::result_type                res;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [sts_pkg::RSP_TDATA_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   sts_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_value  (req_tdata),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   // The output register frees the engine as soon as a transaction is loaded.
   assign res_take      = res_valid && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid_in = res_take || (rsp_tvalid_ff && !rsp_tready);
   assign rsp_tdata_in  = res_take ? res : rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: sim/search_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search result checker
// Watches both channels of the sorted table search. It keeps its own copy of
// the table and predicts each search result, then compares every returned
// transaction field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module search_result_checker
   import sts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // [31:0] value
   input  logic [OP_W-1:0]        req_tuser,   // [1:0] opcode
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // [0] found, [6:1] position, [7] overflow
   output int                     fail_count,
   output int                     results_pending
);

   logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
   int                       shadow_count;
   bit                       shadow_sorted;
   bit                       shadow_overflow;
   result_type               expected_results [$];

   function automatic void sort_shadow_table();
      int                       j;
      logic signed [DATA_W-1:0] v;
      for (int i = 1; i < shadow_count; i++) begin
         v = shadow_table[i];
         j = i;
         while (j > 0 && shadow_table[j-1] > v) begin
            shadow_table[j] = shadow_table[j-1];
            j--;
         end
         shadow_table[j] = v;
      end
   endfunction

   function automatic result_type predict_search(input logic [OP_W-1:0] op,
                                                 input logic signed [DATA_W-1:0] key);
      result_type r;
      int         lo;
      int         hi;
      int         mid;
      r = '0;
      if (!shadow_sorted) begin
         sort_shadow_table();
         shadow_sorted = 1'b1;
      end
      if (op == OP_LINEAR) begin
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_table[i] == key) begin
               r.found    = 1'b1;
               r.position = POS_W'(i);
               break;
            end
         end
      end else begin
         lo = 0;
         hi = shadow_count - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (shadow_table[mid] == key) begin
               r.found    = 1'b1;
               r.position = POS_W'(mid);
               break;
            end
            if (shadow_table[mid] < key) lo = mid + 1;
            else hi = mid - 1;
         end
      end
      // The overflow flag covers loads dropped since the previous search only.
      r.overflow      = shadow_overflow;
      shadow_overflow = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         shadow_count    = 0;
         shadow_sorted   = 1'b1;
         shadow_overflow = 1'b0;
         expected_results.delete();
         fail_count      = 0;
         results_pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata);
            if (expected_results.size() == 0) begin
               $display("%0t: result transaction with none expected, expected none, actual 0x%02h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.found !== want.found)
                  report_mismatch("found", want.found, got.found);
               if (got.position !== want.position)
                  report_mismatch("position", want.position, got.position);
               if (got.overflow !== want.overflow)
                  report_mismatch("overflow", want.overflow, got.overflow);
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_CLEAR: begin
                  shadow_count  = 0;
                  shadow_sorted = 1'b1;
               end
               OP_LOAD: begin
                  if (shadow_count < TABLE_DEPTH) begin
                     shadow_table[shadow_count] = $signed(req_tdata);
                     shadow_count++;
                     shadow_sorted = 1'b0;
                  end else begin
                     shadow_overflow = 1'b1;
                  end
               end
               default: expected_results.push_back(predict_search(req_tuser, $signed(req_tdata)));
            endcase
         end
         results_pending <= expected_results.size();
      end
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table search testbench
// Drives clear, load and search transactions through directed cases and then
// random table build-and-search sequences under several idling patterns,
// including a long result hold-off; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   import sts_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata;   // [31:0] value
   logic [OP_W-1:0]        req_tuser;   // [1:0] opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [0] found, [6:1] position, [7] overflow

   int fail_count;
   int results_pending;
   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   int hold_off_request = 0;
   int items_sent       = 0;
   int phase_target;

   // Values currently in the table, used to pick keys that hit.
   logic [DATA_W-1:0] loaded_values [$];

   sorted_table_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   search_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off counted here on request.
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (op == OP_CLEAR) loaded_values.delete();
      else if (op == OP_LOAD && loaded_values.size() < TABLE_DEPTH) loaded_values.push_back(val);
   endtask

   // Lower valid first, otherwise the last transaction would be offered again.
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_key();
      int c;
      c = $urandom_range(9);
      if (loaded_values.size() != 0 && c < 6)
         return loaded_values[$urandom_range(loaded_values.size() - 1)];
      if (c < 8) return DATA_W'($urandom_range(16)) - DATA_W'(8);
      return $urandom;
   endfunction

   function automatic logic [DATA_W-1:0] pick_load_value(input bit narrow);
      case ($urandom_range(15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         default: return narrow ? DATA_W'($urandom_range(16)) - DATA_W'(8) : $urandom;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_search_op();
      return $urandom_range(1) ? OP_LINEAR : OP_BINARY;
   endfunction

   // Mostly clear, load, then search; now and then a stream of arbitrary opcodes.
   task automatic run_sequence(input bit force_fill);
      int loads;
      bit narrow;
      if (force_fill || $urandom_range(99) < 80) begin
         if (force_fill || $urandom_range(9) != 0) send_item(OP_CLEAR, $urandom);
         if (force_fill || $urandom_range(19) == 0) loads = $urandom_range(60, 72);
         else loads = $urandom_range(1, 10);
         narrow = $urandom_range(1);
         repeat (loads) send_item(OP_LOAD, pick_load_value(narrow));
         // A clear before searching must not lose a pending overflow.
         if ($urandom_range(7) == 0) send_item(OP_CLEAR, $urandom);
         repeat ($urandom_range(1, 6)) send_item(pick_search_op(), pick_key());
      end else begin
         repeat ($urandom_range(1, 8)) send_item(OP_W'($urandom_range(3)), pick_key());
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_CLEAR;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Searches of the empty table, extremes, duplicates, hits and misses.
      send_item(OP_LINEAR, 32'h0000_0000);
      send_item(OP_BINARY, 32'hFFFF_FFFF);
      send_item(OP_LOAD,   32'h7FFF_FFFF);
      send_item(OP_LOAD,   32'h8000_0000);
      send_item(OP_LOAD,   32'h0000_0005);
      send_item(OP_LOAD,   32'hFFFF_FFFF);
      send_item(OP_LOAD,   32'h0000_0000);
      send_item(OP_LOAD,   32'h0000_0005);
      send_item(OP_LOAD,   32'h0001_E240);
      send_item(OP_LINEAR, 32'h8000_0000);
      send_item(OP_BINARY, 32'h7FFF_FFFF);
      send_item(OP_LINEAR, 32'h0000_0005);
      send_item(OP_BINARY, 32'h0000_0005);
      send_item(OP_LINEAR, 32'hFFFF_FFFF);
      send_item(OP_BINARY, 32'h0000_0000);
      send_item(OP_LINEAR, 32'h0000_0003);
      send_item(OP_BINARY, 32'h0000_0003);
      send_item(OP_BINARY, 32'h8000_0000);
      send_item(OP_CLEAR,  32'hFFFF_FFFF);
      send_item(OP_LINEAR, 32'h0000_0005);
      send_item(OP_BINARY, 32'h0000_0005);
      wait_results_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         phase_target = items_sent + 170;
         if (phase == 0) begin
            run_sequence(1'b1);
            wait_results_drained();
            // Hold results back long enough for the block to back up its input.
            hold_off_request = 1500;
            send_item(OP_CLEAR, $urandom);
            repeat (6) send_item(OP_LOAD, pick_load_value(1'b1));
            repeat (24) send_item(pick_search_op(), pick_key());
            wait_results_drained();
         end
         while (items_sent < phase_target) run_sequence(1'b0);
         wait_results_drained();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
